[rtl/core/kerg_pkg.sv]
// Shared types, codes and helpers for the keyed entry run grouper.
package kerg_pkg;

   localparam int KERG_ENTRIES = 64;

   // request codes; bit 1 set means clear
   localparam logic [1:0] REQ_LOAD      = 2'd0;
   localparam logic [1:0] REQ_DRAIN     = 2'd1;
   localparam int         REQ_CLEAR_BIT = 1;

   localparam logic [2:0] STATUS_LOADED  = 3'd0;
   localparam logic [2:0] STATUS_EMITTED = 3'd1;
   localparam logic [2:0] STATUS_FULL    = 3'd2;
   localparam logic [2:0] STATUS_EMPTY   = 3'd3;
   localparam logic [2:0] STATUS_CLEARED = 3'd4;

   localparam logic CSR_BASE_OFFSET = 1'b0;
   localparam logic CSR_SWAP_BYTES  = 1'b1;

   localparam logic [15:0] ID_MAX = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] entry_type;
      logic [15:0] entry_id;
      logic [31:0] entry_offset;
      logic [31:0] entry_length;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_type;
      logic [15:0] out_id;
      logic [31:0] out_offset;
      logic [31:0] out_length;
      logic        run_first;
      logic        run_last;
      logic [6:0]  entries_left;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] key_type;
      logic [15:0] key_id;
      logic [31:0] offset;
      logic [31:0] length;
   } cell_data_type;

   // command from the controller to the cell row
   typedef struct packed {
      logic          load;
      logic          search;
      logic          commit;
      logic          clear;
      logic          run_active;
      cell_data_type new_entry;
      logic [31:0]   run_key;
   } chain_cmd_type;

   // command broadcast to every cell
   typedef struct packed {
      logic          load;
      logic          search;
      logic          commit;
      logic          clear;
      logic          run_active;
      logic          take_run;
      cell_data_type new_entry;
      logic [31:0]   run_key;
      logic [31:0]   run_succ_key;
      logic [31:0]   low_succ_key;
   } cell_cmd_type;

   // drain result from the cell row
   typedef struct packed {
      logic          any_run;
      logic          succ_found;
      cell_data_type pick;
   } chain_status_type;

   function automatic logic [31:0] key_of(input cell_data_type d);
      return {d.key_type, d.key_id};
   endfunction

   // next id of the same type; id wraps inside its own half
   function automatic logic [31:0] key_succ(input logic [31:0] k);
      return {k[31:16], k[15:0] + 16'd1};
   endfunction

   function automatic logic [31:0] byte_rev(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

[rtl/core/kerg_cell.sv]
// One table cell: holds an entry, keeps the row sorted by key and compares keys locally.
module kerg_cell
   import kerg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  cell_data_type prev_data,
   input  logic          prev_valid,
   input  logic          prev_place,
   input  logic          prev_run_hit,
   input  cell_data_type next_data,
   input  logic          next_valid,
   output cell_data_type data,
   output logic          valid,
   output logic          place,
   output logic          run_hit,
   output logic          first_hit,
   output logic          rs_hit,
   output logic          ls_hit
);

   cell_data_type data_ff, data_in;
   logic          valid_ff, valid_in;
   logic          run_hit_ff, run_hit_in;
   logic          run_ge_ff, run_ge_in;
   logic          rs_hit_ff, rs_hit_in;
   logic          ls_hit_ff, ls_hit_in;
   logic [31:0]   key;

   assign key = key_of(data_ff);

   // this slot lies after the new key: equal keys stay ahead so ties keep load order
   assign place = !valid_ff || (key > key_of(cmd.new_entry));

   always_comb begin
      data_in    = data_ff;
      valid_in   = valid_ff;
      run_hit_in = run_hit_ff;
      run_ge_in  = run_ge_ff;
      rs_hit_in  = rs_hit_ff;
      ls_hit_in  = ls_hit_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.load) begin
         if (place) begin
            if (prev_place) begin
               data_in  = prev_data;
               valid_in = prev_valid;
            end else begin
               data_in  = cmd.new_entry;
               valid_in = 1'b1;
            end
         end
      end else if (cmd.search) begin
         run_hit_in = cmd.run_active && valid_ff && (key == cmd.run_key);
         run_ge_in  = key >= cmd.run_key;
         rs_hit_in  = valid_ff && (key == cmd.run_succ_key);
         ls_hit_in  = valid_ff && (key == cmd.low_succ_key);
      end else if (cmd.commit) begin
         // close the gap: the picked cell and all after it advance
         if (!cmd.take_run || run_ge_ff) begin
            data_in  = next_data;
            valid_in = next_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff   <= 1'b0;
         run_hit_ff <= 1'b0;
         run_ge_ff  <= 1'b0;
         rs_hit_ff  <= 1'b0;
         ls_hit_ff  <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         run_hit_ff <= run_hit_in;
         run_ge_ff  <= run_ge_in;
         rs_hit_ff  <= rs_hit_in;
         ls_hit_ff  <= ls_hit_in;
      end
   end

   assign data      = data_ff;
   assign valid     = valid_ff;
   assign run_hit   = run_hit_ff;
   assign first_hit = run_hit_ff && !prev_run_hit;
   assign rs_hit    = rs_hit_ff;
   assign ls_hit    = ls_hit_ff;

endmodule

[rtl/core/kerg_chain.sv]
// Row of table cells with neighbor links, hit reductions and the picked entry.
module kerg_chain
   import kerg_pkg::*;
#(
   parameter int ENTRIES = KERG_ENTRIES
)
(
   input  logic             clock,
   input  logic             reset,
   input  chain_cmd_type    cmd,
   output chain_status_type status
);

   localparam int DATA_W = $bits(cell_data_type);

   cell_data_type        data_a [ENTRIES];
   logic [ENTRIES-1:0]   valid_v;
   logic [ENTRIES-1:0]   place_v;
   logic [ENTRIES-1:0]   run_hit_v;
   logic [ENTRIES-1:0]   first_v;
   logic [ENTRIES-1:0]   rs_v;
   logic [ENTRIES-1:0]   ls_v;
   cell_cmd_type         cell_cmd;
   logic                 any_run;
   logic [DATA_W-1:0]    run_pick;

   assign any_run = |run_hit_v;

   always_comb begin
      cell_cmd.load         = cmd.load;
      cell_cmd.search       = cmd.search;
      cell_cmd.commit       = cmd.commit;
      cell_cmd.clear        = cmd.clear;
      cell_cmd.run_active   = cmd.run_active;
      cell_cmd.take_run     = any_run;
      cell_cmd.new_entry    = cmd.new_entry;
      cell_cmd.run_key      = cmd.run_key;
      cell_cmd.run_succ_key = key_succ(cmd.run_key);
      cell_cmd.low_succ_key = key_succ(key_of(data_a[0]));
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      cell_data_type prev_data;
      logic          prev_valid;
      logic          prev_place;
      logic          prev_run_hit;
      cell_data_type next_data;
      logic          next_valid;

      if (i == 0) begin : g_head
         assign prev_data    = '0;
         assign prev_valid   = 1'b0;
         assign prev_place   = 1'b0;
         assign prev_run_hit = 1'b0;
      end else begin : g_body
         assign prev_data    = data_a[i-1];
         assign prev_valid   = valid_v[i-1];
         assign prev_place   = place_v[i-1];
         assign prev_run_hit = run_hit_v[i-1];
      end

      if (i == ENTRIES - 1) begin : g_tail
         assign next_data  = '0;
         assign next_valid = 1'b0;
      end else begin : g_link
         assign next_data  = data_a[i+1];
         assign next_valid = valid_v[i+1];
      end

      kerg_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cell_cmd),
         .prev_data    (prev_data),
         .prev_valid   (prev_valid),
         .prev_place   (prev_place),
         .prev_run_hit (prev_run_hit),
         .next_data    (next_data),
         .next_valid   (next_valid),
         .data         (data_a[i]),
         .valid        (valid_v[i]),
         .place        (place_v[i]),
         .run_hit      (run_hit_v[i]),
         .first_hit    (first_v[i]),
         .rs_hit       (rs_v[i]),
         .ls_hit       (ls_v[i])
      );
   end

   // first matching cell is one-hot, so an AND-OR picks it
   always_comb begin
      run_pick = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (first_v[i]) begin
            run_pick = run_pick | data_a[i];
         end
      end
   end

   assign status.any_run    = any_run;
   assign status.succ_found = any_run ? (|rs_v) : (|ls_v);
   assign status.pick       = any_run ? cell_data_type'(run_pick) : data_a[0];

endmodule

[rtl/core/keyed_entry_run_grouper.sv]
// Top level: request decode, drain sequencing, run tracking and result register.
//
//   channel | ports                               | direction | payload
//   --------+-------------------------------------+-----------+------------------
//   request | req_valid, req_stall, req_payload   | in        | req_payload_type
//   result  | rsp_valid, rsp_stall, rsp_payload   | out       | rsp_payload_type
//   config  | csr_write_en, csr_index, csr_wdata  | in        | 32-bit write data
//
// Load, clear, full and empty requests: the result register loads at the accepting edge.
// Drain: a key compare in every cell at the accepting edge, then pick, shift of the
// cell row and result register load at the next edge.
// req_stall is high in the drain commit phase and while a result is held under rsp_stall.
// Synchronous reset empties the table at once through the per-cell valid bits.
// Table holds ENTRIES entries kept sorted by key in the cell row.
module keyed_entry_run_grouper
   import kerg_pkg::*;
#(
   parameter int ENTRIES = KERG_ENTRIES
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_en,
   input  logic            csr_index,
   input  logic [31:0]     csr_wdata
);

   localparam int   CNT_W     = $clog2(ENTRIES + 1);
   localparam logic PH_IDLE   = 1'b0;
   localparam logic PH_COMMIT = 1'b1;

   logic             phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             run_active_ff, run_active_in;
   logic [31:0]      run_key_ff, run_key_in;
   logic [31:0]      base_ff, base_in;
   logic             swap_ff, swap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   chain_cmd_type    cmd;
   chain_status_type chain_status;
   rsp_payload_type  result;
   logic             produce;
   logic             accept;
   logic [31:0]      off_sum;
   logic             last;

   assign req_stall = (phase_ff == PH_COMMIT) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign off_sum = chain_status.pick.offset + base_ff;
   assign last    = (chain_status.pick.key_id == ID_MAX) || !chain_status.succ_found;

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      run_active_in = run_active_ff;
      run_key_in    = run_key_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      result        = '0;
      produce       = 1'b0;

      cmd            = '0;
      cmd.run_active = run_active_ff;
      cmd.run_key    = run_key_ff;
      cmd.new_entry  = {req_payload.entry_type, req_payload.entry_id,
                        req_payload.entry_offset, req_payload.entry_length};

      if (phase_ff == PH_COMMIT) begin
         cmd.commit       = 1'b1;
         phase_in         = PH_IDLE;
         count_in         = count_ff - CNT_W'(1);
         result.status    = STATUS_EMITTED;
         result.out_type  = chain_status.pick.key_type;
         result.out_id    = chain_status.pick.key_id;
         result.out_offset = swap_ff ? byte_rev(off_sum) : off_sum;
         result.out_length = swap_ff ? byte_rev(chain_status.pick.length)
                                     : chain_status.pick.length;
         result.run_first = !chain_status.any_run;
         result.run_last  = last;
         run_active_in    = !last;
         run_key_in       = key_succ({chain_status.pick.key_type, chain_status.pick.key_id});
         produce          = 1'b1;
      end else if (accept) begin
         case (req_payload.req_type)
            REQ_LOAD: begin
               if (count_ff == CNT_W'(ENTRIES)) begin
                  result.status = STATUS_FULL;
               end else begin
                  cmd.load      = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  result.status = STATUS_LOADED;
               end
               produce = 1'b1;
            end
            REQ_DRAIN: begin
               if (count_ff == '0) begin
                  result.status = STATUS_EMPTY;
                  produce       = 1'b1;
               end else begin
                  // compare keys now, pick and shift next cycle
                  cmd.search = 1'b1;
                  phase_in   = PH_COMMIT;
               end
            end
            default: begin
               cmd.clear     = 1'b1;
               count_in      = '0;
               run_active_in = 1'b0;
               run_key_in    = '0;
               result.status = STATUS_CLEARED;
               produce       = 1'b1;
            end
         endcase
      end

      if (produce) begin
         rsp_in              = result;
         rsp_in.entries_left = 7'(count_in);
         rsp_valid_in        = 1'b1;
      end
   end

   always_comb begin
      base_in = base_ff;
      swap_in = swap_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_BASE_OFFSET: base_in = csr_wdata;
            CSR_SWAP_BYTES:  swap_in = csr_wdata[0];
            default: begin
               base_in = base_ff;
            end
         endcase
      end
   end

   kerg_chain #(
      .ENTRIES (ENTRIES)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (chain_status)
   );

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         phase_ff      <= PH_IDLE;
         count_ff      <= '0;
         run_active_ff <= 1'b0;
         run_key_ff    <= '0;
         base_ff       <= '0;
         swap_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         run_active_ff <= run_active_in;
         run_key_ff    <= run_key_in;
         base_ff       <= base_in;
         swap_ff       <= swap_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_commit_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COMMIT) |=> (phase_ff == PH_IDLE))
      else $error("drain commit phase lasted more than one cycle");

   a_commit_emits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COMMIT) |=> (rsp_valid_ff && (rsp_ff.status == STATUS_EMITTED)))
      else $error("drain commit did not register an emitted entry");

   a_commit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COMMIT) |-> (count_ff != '0))
      else $error("drain commit with an empty table");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count above table size");
`endif

endmodule
